### design/decimal_text_to_float32_assert.svh
// Assertion macros for the decimal text to float32 converter.
`ifndef DECIMAL_TEXT_TO_FLOAT32_ASSERT_SVH
`define DECIMAL_TEXT_TO_FLOAT32_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define DTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define DTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/dtf_pkg.sv
// Shared types, constants and tables for the decimal text to float32 converter.
`default_nettype none

package dtf_pkg;

    localparam int MAX_DIGITS  = 9;
    localparam int CNT_W       = 4;
    localparam int DEN_W       = 30;
    localparam int QUEUE_DEPTH = 2;
    localparam int EXP_BIAS    = 127;
    localparam int MANT_BITS   = 23;
    localparam int LEAD_LIMIT  = 63;

    localparam logic [7:0] DIGIT_FLOOR = 8'h2e;
    localparam logic [7:0] MINUS_CHAR  = 8'h2d;

    typedef logic [1:0] t_mode;
    typedef logic [1:0] t_status;

    localparam t_mode MODE_FLOAT = 2'd0;
    localparam t_mode MODE_INT   = 2'd1;
    localparam t_mode MODE_INDEX = 2'd2;

    localparam t_status STAT_OK     = 2'd0;
    localparam t_status STAT_BIG    = 2'd1;
    localparam t_status STAT_DIGITS = 2'd2;

    typedef struct packed {
        t_mode              mode;
        logic [31:0]        ipart;
        logic [31:0]        frac;
        logic [CNT_W-1:0]   count;
        logic               neg;
        logic               ovf;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [DEN_W-1:0] pow10(input logic [CNT_W-1:0] k);
        logic [DEN_W-1:0] v;
        case (k)
            4'd0:    v = 30'd1;
            4'd1:    v = 30'd10;
            4'd2:    v = 30'd100;
            4'd3:    v = 30'd1000;
            4'd4:    v = 30'd10000;
            4'd5:    v = 30'd100000;
            4'd6:    v = 30'd1000000;
            4'd7:    v = 30'd10000000;
            4'd8:    v = 30'd100000000;
            default: v = 30'd1000000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### design/dtf_if.sv
// Handshake channels: text bytes in, mode writes in, converted words out.
`default_nettype none

interface dtf_byte_if import dtf_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    modport source (output valid, output char_byte, input ready);
    modport sink (input valid, input char_byte, output ready);
endinterface

interface dtf_cfg_if import dtf_pkg::*;;
    logic  valid;
    logic  ready;
    t_mode number_mode;
    modport source (output valid, output number_mode, input ready);
    modport sink (input valid, input number_mode, output ready);
endinterface

interface dtf_result_if import dtf_pkg::*;;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    t_status     status;
    modport source (output valid, output result_value, output status, input ready);
    modport sink (input valid, input result_value, input status, output ready);
endinterface

`default_nettype wire

### design/dtf_front.sv
// Front end: parses text bytes into fields and queues finished numbers.
`default_nettype none

module dtf_front import dtf_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dtf_byte_if.sink    i_char,
    dtf_cfg_if.sink     i_cfg,
    input  wire logic   i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    t_mode            r_mode,       n_mode;
    logic [31:0]      r_accum,      n_accum;
    logic [CNT_W-1:0] r_count,      n_count;
    logic             r_minus,      n_minus;
    logic             r_frac_phase, n_frac_phase;
    logic [31:0]      r_saved,      n_saved;
    logic             r_ovf,        n_ovf;

    logic accept;
    logic is_digit;
    logic is_minus;
    logic float_mode;

    assign i_char.ready = !i_q_full;
    assign i_cfg.ready  = 1'b1;

    assign accept     = i_char.valid && i_char.ready;
    assign is_digit   = i_char.char_byte > DIGIT_FLOOR;
    assign is_minus   = i_char.char_byte == MINUS_CHAR;
    assign float_mode = r_mode == MODE_FLOAT;

    assign o_push = accept && !is_digit && !is_minus && !(float_mode && !r_frac_phase);
    assign o_job  = '{mode: r_mode, ipart: r_saved, frac: r_accum, count: r_count,
                      neg: r_minus, ovf: r_ovf};

    always_comb begin
        n_mode       = r_mode;
        n_accum      = r_accum;
        n_count      = r_count;
        n_minus      = r_minus;
        n_frac_phase = r_frac_phase;
        n_saved      = r_saved;
        n_ovf        = r_ovf;
        if (i_cfg.valid && i_cfg.ready) begin
            n_mode = i_cfg.number_mode;
        end
        if (accept) begin
            if (is_digit) begin
                if (r_count < CNT_W'(MAX_DIGITS)) begin
                    n_accum = (r_accum << 3) + (r_accum << 1)
                              + {28'd0, i_char.char_byte[3:0]};
                    n_count = r_count + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end else if (is_minus) begin
                // drop a minus sign inside a float fraction
                if (!(float_mode && r_frac_phase)) begin
                    n_minus = 1'b1;
                end
            end else if (float_mode && !r_frac_phase) begin
                n_saved      = r_accum;
                n_frac_phase = 1'b1;
                n_accum      = '0;
                n_count      = '0;
            end else begin
                n_accum      = '0;
                n_count      = '0;
                n_minus      = 1'b0;
                n_frac_phase = 1'b0;
                n_saved      = '0;
                n_ovf        = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_FLOAT;
            r_accum      <= '0;
            r_count      <= '0;
            r_minus      <= 1'b0;
            r_frac_phase <= 1'b0;
            r_saved      <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_accum      <= n_accum;
            r_count      <= n_count;
            r_minus      <= n_minus;
            r_frac_phase <= n_frac_phase;
            r_saved      <= n_saved;
            r_ovf        <= n_ovf;
        end
    end

endmodule

`default_nettype wire

### design/dtf_queue.sv
// Short job queue between the parser and the converter.
`default_nettype none

module dtf_queue import dtf_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_job   i_job,
    input  wire logic   i_pop,
    output t_job        o_job,
    output t_q_stat     o_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_fill,   n_fill;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = r_fill == CNT_QW'(QUEUE_DEPTH);
    assign o_stat.empty = r_fill == '0;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_fill = r_fill + 1'b1;
            2'b01:   n_fill = r_fill - 1'b1;
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

`default_nettype wire

### design/dtf_back.sv
// Back end: turns queued numbers into float32 or integer words, float mantissa bits one a cycle.
`default_nettype none

module dtf_back import dtf_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_job   i_job,
    input  wire t_q_stat i_stat,
    output logic        o_pop,
    dtf_result_if.source o_result
);

    typedef enum logic [1:0] {S_IDLE, S_LEAD, S_BITS, S_DONE} t_state;

    t_state           r_state,  n_state;
    logic [DEN_W-1:0] r_rem,    n_rem;
    logic [DEN_W-1:0] r_den,    n_den;
    logic [23:0]      r_mant,   n_mant;
    logic [7:0]       r_exp,    n_exp;
    logic [4:0]       r_nbits,  n_nbits;
    logic [6:0]       r_m,      n_m;
    logic             r_neg,    n_neg;
    logic             r_float,  n_float;
    logic [31:0]      r_int,    n_int;
    t_status          r_stat,   n_stat;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_value, n_out_value;
    t_status          r_out_status, n_out_status;

    logic [DEN_W-1:0] den_j;
    logic [32:0]      frac_diff;
    logic [DEN_W-1:0] rem_j;
    logic [4:0]       lead_e;
    logic [DEN_W:0]   rem2;
    logic             nbit;
    logic [DEN_W-1:0] rem_nx;
    logic [31:0]      int_val;

    assign o_pop = (r_state == S_IDLE) && !i_stat.empty;

    // Reduce the fraction below its power of ten; it stays below twice that.
    assign den_j     = pow10(i_job.count);
    assign frac_diff = {1'b0, i_job.frac} - {3'b0, den_j};
    assign rem_j     = frac_diff[32] ? i_job.frac[DEN_W-1:0] : frac_diff[DEN_W-1:0];

    always_comb begin
        lead_e = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_job.ipart[i]) begin
                lead_e = 5'(i);
            end
        end
    end

    // One step of binary long division of the remainder by the power of ten.
    assign rem2   = {r_rem, 1'b0};
    assign nbit   = rem2 >= {1'b0, r_den};
    assign rem_nx = nbit ? DEN_W'(rem2 - {1'b0, r_den}) : rem2[DEN_W-1:0];

    always_comb begin
        int_val = i_job.neg ? (32'd0 - i_job.frac) : i_job.frac;
        if (i_job.mode == MODE_INDEX) begin
            int_val = int_val - 32'd1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_rem        = r_rem;
        n_den        = r_den;
        n_mant       = r_mant;
        n_exp        = r_exp;
        n_nbits      = r_nbits;
        n_m          = r_m;
        n_neg        = r_neg;
        n_float      = r_float;
        n_int        = r_int;
        n_stat       = r_stat;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_rem   = rem_j;
                    n_den   = den_j;
                    n_neg   = i_job.neg;
                    n_int   = int_val;
                    n_float = i_job.mode == MODE_FLOAT;
                    n_stat  = i_job.ovf ? STAT_DIGITS : STAT_OK;
                    n_mant  = '0;
                    n_exp   = '0;
                    n_state = S_DONE;
                    if (i_job.mode == MODE_FLOAT) begin
                        if (i_job.ipart != '0) begin
                            n_exp = 8'(lead_e) + 8'(EXP_BIAS);
                            if (lead_e > 5'(MANT_BITS)) begin
                                // keep the top 24 bits, no fraction bits
                                n_mant = 24'(i_job.ipart >> (lead_e - 5'(MANT_BITS)));
                                if (!i_job.ovf) begin
                                    n_stat = STAT_BIG;
                                end
                            end else begin
                                n_mant  = i_job.ipart[23:0];
                                n_nbits = 5'(MANT_BITS) - lead_e;
                                if (lead_e != 5'(MANT_BITS)) begin
                                    n_state = S_BITS;
                                end
                            end
                        end else if (rem_j != '0) begin
                            n_m     = 7'd1;
                            n_state = S_LEAD;
                        end
                    end
                end
            end
            S_LEAD: begin
                n_rem = rem_nx;
                if (nbit || r_m == 7'(LEAD_LIMIT)) begin
                    n_exp   = 8'(EXP_BIAS) - (nbit ? {1'b0, r_m} : 8'(r_m + 1'b1));
                    n_nbits = 5'(MANT_BITS);
                    n_state = S_BITS;
                end else begin
                    n_m = r_m + 1'b1;
                end
            end
            S_BITS: begin
                n_rem   = rem_nx;
                n_mant  = {r_mant[22:0], nbit};
                n_nbits = r_nbits - 1'b1;
                if (r_nbits == 5'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_float ? {r_neg, r_exp, r_mant[22:0]} : r_int;
                    n_out_status = r_stat;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_rem        <= n_rem;
        r_den        <= n_den;
        r_mant       <= n_mant;
        r_exp        <= n_exp;
        r_nbits      <= n_nbits;
        r_m          <= n_m;
        r_neg        <= n_neg;
        r_float      <= n_float;
        r_int        <= n_int;
        r_stat       <= n_stat;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.result_value = r_out_value;
    assign o_result.status       = r_out_status;

endmodule

`default_nettype wire

### design/decimal_text_to_float32.sv
// Top level: ASCII number text to IEEE single or integer words.
// Bytes are taken one per cycle while the two-entry job queue has room.
// Words go from the job queue via the done state to the output register, one number at a time;
// a float word first steps through each mantissa bit below its integer part, or with no
// integer part each fraction bit up to the leading one and then each mantissa bit.
// Synchronous active-low reset clears parse state, queue and output valid.
`default_nettype none
`include "decimal_text_to_float32_assert.svh"

module decimal_text_to_float32 import dtf_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    dtf_byte_if.sink     i_char,
    dtf_cfg_if.sink      i_cfg,
    dtf_result_if.source o_result
);

    logic    w_push;
    logic    w_pop;
    t_job    w_job_in;
    t_job    w_job_out;
    t_q_stat w_stat;

    dtf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_cfg    (i_cfg),
        .i_q_full (w_stat.full),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    dtf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_stat  (w_stat)
    );

    dtf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_job_out),
        .i_stat   (w_stat),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

    `DTF_ASSERT_NOW(a_push_room, w_push, !w_stat.full, "number pushed into a full queue")
    `DTF_ASSERT_NOW(a_pop_data, w_pop, !w_stat.empty, "converter popped an empty queue")
    `DTF_ASSERT_NEXT(a_push_kept, w_push && w_stat.empty && !w_pop, !w_stat.empty, "queue lost a word")
    `DTF_ASSERT_NOW(a_status_code, o_result.valid, o_result.status <= STAT_DIGITS, "bad status code")

endmodule

`default_nettype wire

### test/decimal_text_to_float32_test.sv
// Self-checking testbench for the decimal text to float32 converter.
`timescale 1ns / 100ps

module decimal_text_to_float32_test;
    import dtf_pkg::*;

    localparam t_mode MODE_SPARE  = 2'd3;
    localparam int    SETTLE_CYC  = 100;
    localparam int    PHASE_BYTES = 250;

    // Running parse of the text stream and the words it must produce.
    class float_text_scoreboard;
        t_mode       mode;
        logic [31:0] accum;
        logic [3:0]  ndigits;
        bit          minus;
        bit          in_frac;
        bit          ovf;
        logic [31:0] int_part;
        logic [63:0] rem;
        logic [63:0] den;
        logic [31:0] word_q[$];
        t_status     status_q[$];
        int          mismatches;

        function new();
            mode       = MODE_FLOAT;
            mismatches = 0;
            clear_number();
        endfunction

        function void clear_number();
            accum    = '0;
            ndigits  = '0;
            minus    = 1'b0;
            in_frac  = 1'b0;
            ovf      = 1'b0;
            int_part = '0;
        endfunction

        function void set_mode(t_mode m);
            mode = m;
        endfunction

        function int pending();
            return word_q.size();
        endfunction

        // One step of long division of rem by den.
        function bit div_step();
            rem = rem << 1;
            if (rem >= den) begin
                rem = rem - den;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [31:0] to_single(logic [31:0] ipart, logic [31:0] frac,
                                        logic [3:0] k, output bit too_big);
            int          e;
            int          m;
            int          i;
            int          expf;
            logic [31:0] mant;
            den = 64'd1;
            for (i = 0; i < int'(k) && i < 9; i++)
                den = den * 10;
            rem = frac;
            if (rem >= den)
                rem = rem % den;
            too_big = 1'b0;
            mant    = '0;
            expf    = 0;
            e       = 0;
            if (ipart != 0) begin
                while (e < 31 && (ipart >> (e + 1)) != 0)
                    e++;
                if (e > 23) begin
                    too_big = 1'b1;
                    mant    = (ipart >> (e - 23)) & 32'h7fffff;
                end else begin
                    mant = (ipart << (23 - e)) & 32'h7fffff;
                    for (i = 0; i < 23 - e; i++)
                        if (div_step())
                            mant[22 - e - i] = 1'b1;
                end
                expf = e + 127;
            end else if (rem != 0) begin
                // count leading zero bits up to and including the first one
                m = 1;
                while (m < 64) begin
                    if (div_step())
                        break;
                    m++;
                end
                for (i = 0; i < 23; i++)
                    mant = {mant[30:0], div_step()};
                expf = (m < 127) ? 127 - m : 0;
            end
            return {minus, expf[7:0], mant[22:0]};
        endfunction

        function void take_byte(logic [7:0] b);
            logic [31:0] v;
            t_status     st;
            bit          big;
            if (b > DIGIT_FLOOR) begin
                if (ndigits < MAX_DIGITS) begin
                    accum   = accum * 10 + b[3:0];
                    ndigits = ndigits + 1;
                end else begin
                    ovf = 1'b1;
                end
                return;
            end
            if (b == MINUS_CHAR) begin
                if (!(mode == MODE_FLOAT && in_frac))
                    minus = 1'b1;
                return;
            end
            if (mode == MODE_FLOAT) begin
                if (!in_frac) begin
                    // hold the integer part, start the fraction field
                    int_part = accum;
                    in_frac  = 1'b1;
                    accum    = '0;
                    ndigits  = '0;
                    return;
                end
                v  = to_single(int_part, accum, ndigits, big);
                st = ovf ? STAT_DIGITS : (big ? STAT_BIG : STAT_OK);
            end else begin
                v = minus ? -accum : accum;
                if (mode == MODE_INDEX)
                    v = v - 1;
                st = ovf ? STAT_DIGITS : STAT_OK;
            end
            word_q.push_back(v);
            status_q.push_back(st);
            clear_number();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_word(logic [31:0] v, t_status s);
            logic [31:0] exp_v;
            t_status     exp_s;
            if (word_q.size() == 0) begin
                report($sformatf("unexpected word %h status %0d", v, s));
                return;
            end
            exp_v = word_q.pop_front();
            exp_s = status_q.pop_front();
            if (v !== exp_v || s !== exp_s)
                report($sformatf("expected %h status %0d, got %h status %0d",
                                 exp_v, exp_s, v, s));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   steady;
    int   sent_bytes;

    dtf_byte_if   char_if();
    dtf_cfg_if    cfg_if();
    dtf_result_if result_if();

    float_text_scoreboard sb;

    decimal_text_to_float32 u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .i_cfg   (cfg_if),
        .o_result(result_if)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: stall at random unless in the steady stretch.
    always @(negedge i_clk) begin
        result_if.ready <= steady || ($urandom_range(0, 99) >= 11);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            sb.check_word(result_if.result_value, result_if.status);
    end

    task automatic send_char(input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 11) begin
            @(negedge i_clk);
            char_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        char_if.valid     <= 1'b1;
        char_if.char_byte <= b;
        do @(posedge i_clk); while (!char_if.ready);
        sb.take_byte(b);
        sent_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic drain();
        @(negedge i_clk);
        char_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.number_mode <= m;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_mode(m);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_digit();
        if ($urandom_range(0, 99) < 85)
            return 8'h30 + 8'($urandom_range(0, 9));
        return 8'($urandom_range(int'(DIGIT_FLOOR) + 1, 255));
    endfunction

    function automatic logic [7:0] pick_end();
        int r;
        r = $urandom_range(0, 3);
        if (r < 2)
            return 8'h2e;
        if (r == 2)
            return 8'h20;
        return 8'($urandom_range(0, int'(MINUS_CHAR) - 1));
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 0;
        if (r < 8)
            return $urandom_range(1, 4);
        if (r == 8)
            return $urandom_range(5, 9);
        return $urandom_range(10, 12);
    endfunction

    task automatic send_digits(input int n, input int zeros);
        for (int i = 0; i < n; i++)
            send_char(i < zeros ? 8'h30 : pick_digit());
    endtask

    // One number in the current mode, now and then noise instead.
    task automatic send_number(input t_mode m);
        int nint;
        int nfrac;
        int zeros;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
                send_char(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 99) < 35)
            send_char(MINUS_CHAR);
        nint = pick_len();
        send_digits(nint, 0);
        send_char(pick_end());
        if (m == MODE_FLOAT) begin
            if ($urandom_range(0, 9) == 0)
                send_char(MINUS_CHAR);
            nfrac = pick_len();
            zeros = ($urandom_range(0, 2) == 0) ? $urandom_range(0, nfrac) : 0;
            send_digits(nfrac, zeros);
            send_char(pick_end());
        end
    endtask

    initial begin
        #20_000_000;
        $display("decimal_text_to_float32_test NOT OK");
        $finish;
    end

    initial begin
        t_mode phase_mode[8];
        int    target;
        bit    paused;
        phase_mode = '{MODE_FLOAT, MODE_INT, MODE_INDEX, MODE_SPARE,
                       MODE_FLOAT, MODE_INDEX, MODE_FLOAT, MODE_INT};
        sb                 = new();
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        steady             = 1'b0;
        sent_bytes         = 0;
        char_if.valid      = 1'b0;
        char_if.char_byte  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.number_mode = MODE_FLOAT;
        result_if.ready    = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: signed zero with a minus in the fraction, large integer
        // part, digit bytes at both ends, too many digits, empty field
        write_mode(MODE_FLOAT);
        send_text("-.-0,");
        send_char(8'h31);
        send_char(8'hff);
        send_text("000000.");
        send_char(8'h00);
        write_mode(MODE_INT);
        send_text("-/123456789 ");
        write_mode(MODE_INDEX);
        send_text(".");
        write_mode(MODE_SPARE);
        send_text("7 ");

        for (int p = 0; p < 8; p++) begin
            write_mode(phase_mode[p]);
            steady = (p == 4);
            paused = 1'b0;
            target = sent_bytes + PHASE_BYTES;
            while (sent_bytes < target) begin
                send_number(phase_mode[p]);
                if (p == 0 && !paused && sent_bytes > target - PHASE_BYTES / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end
        steady = 1'b0;

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("decimal_text_to_float32_test OK");
        end else begin
            $display("decimal_text_to_float32_test NOT OK");
        end
        $finish;
    end

endmodule
